// ===== hw/rtl/tfp_pkg.sv =====
// ---------------------------------------------------------------------------
// tfp_pkg
// Shared types and constants for the one-pass fastest temporal path engine.
// ---------------------------------------------------------------------------
package tfp_pkg;

    localparam int VERTICES_DEF   = 1024;
    localparam int LIST_DEPTH_DEF = 16;
    localparam int TW             = 31;
    localparam int VPW            = 10;
    localparam int VT_WIDTH_DEF   = 1 + TW + VPW + $clog2(LIST_DEPTH_DEF + 1);

    localparam logic [TW-1:0] TMAX = '1;

    typedef enum logic [1:0] {
        CMD_EDGE,
        CMD_READ,
        CMD_CLEAR,
        CMD_NOP
    } t_cmd;

    typedef enum logic [1:0] {
        CFG_SOURCE,
        CFG_WSTART,
        CFG_WEND
    } t_cfg;

    typedef enum logic {
        LOP_SEARCH,
        LOP_ADD
    } t_lop;

    typedef struct packed {
        logic go;
        t_lop op;
    } t_lreq;

    typedef struct packed {
        logic done;
        logic found;
        logic ovf;
    } t_lrsp;

    typedef enum logic [1:0] {
        PH_TAIL,
        PH_MID,
        PH_KEEP
    } t_phase;

    typedef enum logic [2:0] {
        L_IDLE,
        L_S_RD,
        L_S_EV,
        L_A_RD,
        L_A_EV,
        L_W_RD,
        L_W_WR,
        L_DONE
    } t_lstate;

    typedef enum logic [3:0] {
        T_CLR,
        T_IDLE,
        T_ZERO,
        T_SA_RD,
        T_SA_GO,
        T_SA_WT,
        T_F_RD,
        T_F_GO,
        T_F_WT,
        T_T_RD,
        T_T_GO,
        T_T_WT,
        T_RV,
        T_RV2
    } t_tstate;

endpackage

// ===== hw/rtl/tfp_vtab.sv =====
// ---------------------------------------------------------------------------
// tfp_vtab
// Per-vertex table: one write port, one registered read port.
// ---------------------------------------------------------------------------
module tfp_vtab #(
    parameter int DEPTH = tfp_pkg::VERTICES_DEF,
    parameter int WIDTH = tfp_pkg::VT_WIDTH_DEF,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_rd,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_rd) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;

endmodule

// ===== hw/rtl/tfp_list.sv =====
// ---------------------------------------------------------------------------
// tfp_list
// Journey pair lists: binary search for the last pair arriving in time, and
// pruned insertion by a backward scan followed by an in-order rewrite.
// ---------------------------------------------------------------------------
module tfp_list #(
    parameter int VERTICES   = tfp_pkg::VERTICES_DEF,
    parameter int LIST_DEPTH = tfp_pkg::LIST_DEPTH_DEF,
    localparam int VW = $clog2(VERTICES),
    localparam int CW = $clog2(LIST_DEPTH + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  tfp_pkg::t_lreq        i_req,
    input  logic [VW-1:0]         i_vert,
    input  logic [tfp_pkg::TW-1:0] i_s,
    input  logic [tfp_pkg::TW-1:0] i_a,
    input  logic [CW-1:0]         i_cnt,
    output tfp_pkg::t_lrsp        o_rsp,
    output logic [tfp_pkg::TW-1:0] o_st,
    output logic [CW-1:0]         o_cnt
);
    import tfp_pkg::*;

    localparam int IW  = $clog2(LIST_DEPTH);
    localparam int PD  = VERTICES * LIST_DEPTH;
    localparam int PAW = $clog2(PD);
    localparam int PW  = 2 * TW;

    logic [PW-1:0] r_pmem [PD];
    logic [PW:0]   r_smem [LIST_DEPTH];
    logic [PW-1:0] r_pq;
    logic [PW:0]   r_sq;

    t_lstate       r_state, n_state;
    logic [PAW-1:0] r_base;
    logic [TW-1:0] r_s, r_a, r_st;
    logic [CW-1:0] r_n, r_lo, r_hi, r_m, r_j, r_ins, r_nd, r_k, r_w;
    t_phase        r_ph;
    logic          r_skip, r_newdone, r_ovf;

    logic [TW-1:0] e_st, e_ar;
    logic          lo_lt_hi, abort_c, del_c, drop_c, take_new, live;
    logic [CW:0]   sum_c, nn_c;
    logic [CW-1:0] m_c, j_idx;

    logic           p_rd, p_we, s_rd, s_we;
    logic [PAW-1:0] p_ra, p_wa;
    logic [PW-1:0]  p_wd;
    logic [IW-1:0]  s_wa, s_ra;
    logic [PW:0]    s_wd;

    assign e_st     = r_pq[PW-1:TW];
    assign e_ar     = r_pq[TW-1:0];
    assign lo_lt_hi = r_lo < r_hi;
    assign sum_c    = {1'b0, r_lo} + {1'b0, r_hi} - (CW+1)'(1);
    assign m_c      = sum_c[CW:1];
    assign j_idx    = r_j - CW'(1);
    assign abort_c  = (r_ph == PH_TAIL) && (e_st >= r_s) && (e_ar <= r_a);
    assign del_c    = (r_ph != PH_KEEP) && (e_st <= r_s) && (e_ar >= r_a);
    assign nn_c     = {1'b0, r_n} + (CW+1)'(1) - {1'b0, r_nd};
    assign drop_c   = nn_c > (CW+1)'(LIST_DEPTH);
    assign take_new = !r_newdone && (r_k == r_ins);
    assign live     = take_new || !r_sq[PW];

    always_comb begin
        case (r_state)
            L_IDLE: begin
                if (i_req.go) begin
                    n_state = (i_req.op == LOP_SEARCH) ? L_S_RD : L_A_RD;
                end else begin
                    n_state = L_IDLE;
                end
            end
            L_S_RD: n_state = lo_lt_hi ? L_S_EV : L_DONE;
            L_S_EV: n_state = L_S_RD;
            L_A_RD: n_state = (r_j != '0) ? L_A_EV : L_W_RD;
            L_A_EV: n_state = abort_c ? L_DONE : L_A_RD;
            L_W_RD: n_state = (r_newdone && (r_k == r_n)) ? L_DONE : L_W_WR;
            L_W_WR: n_state = L_W_RD;
            L_DONE: n_state = L_IDLE;
            default: n_state = L_IDLE;
        endcase
    end

    always_comb begin
        p_rd  = 1'b0;
        p_ra  = r_base;
        p_we  = 1'b0;
        p_wa  = r_base + PAW'(r_w);
        p_wd  = take_new ? {r_s, r_a} : r_sq[PW-1:0];
        s_we  = 1'b0;
        s_wa  = j_idx[IW-1:0];
        s_wd  = {del_c, r_pq};
        s_rd  = 1'b0;
        s_ra  = r_k[IW-1:0];
        o_rsp = '0;
        case (r_state)
            L_S_RD: begin
                p_rd = lo_lt_hi;
                p_ra = r_base + PAW'(m_c);
            end
            L_A_RD: begin
                p_rd = (r_j != '0);
                p_ra = r_base + PAW'(j_idx);
            end
            L_A_EV: s_we = !abort_c;
            L_W_RD: s_rd = r_k < r_n;
            L_W_WR: p_we = live && !r_skip;
            L_DONE: o_rsp.done = 1'b1;
            default: ;
        endcase
        o_rsp.found = (r_lo != '0);
        o_rsp.ovf   = r_ovf;
    end

    always_ff @(posedge i_clk) begin
        if (p_we) begin
            r_pmem[p_wa] <= p_wd;
        end
        if (p_rd) begin
            r_pq <= r_pmem[p_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_we) begin
            r_smem[s_wa] <= s_wd;
        end
        if (s_rd) begin
            r_sq <= r_smem[s_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            L_IDLE: begin
                if (i_req.go) begin
                    r_base <= PAW'(i_vert) * PAW'(LIST_DEPTH);
                    r_s    <= i_s;
                    r_a    <= i_a;
                    r_n    <= i_cnt;
                    r_lo   <= '0;
                    r_hi   <= i_cnt;
                    r_j    <= i_cnt;
                    r_ins  <= i_cnt;
                    r_nd   <= '0;
                    r_ph   <= PH_TAIL;
                    r_ovf  <= 1'b0;
                    r_w    <= i_cnt;
                end
            end
            L_S_RD: r_m <= m_c;
            L_S_EV: begin
                if (e_ar <= r_s) begin
                    r_lo <= r_m + CW'(1);
                    r_st <= e_st;
                end else begin
                    r_hi <= r_m;
                end
            end
            L_A_RD: begin
                if (r_j == '0) begin
                    r_skip    <= drop_c;
                    r_ovf     <= drop_c;
                    r_k       <= '0;
                    r_w       <= '0;
                    r_newdone <= 1'b0;
                end
            end
            L_A_EV: begin
                if (!abort_c) begin
                    r_j  <= j_idx;
                    r_nd <= r_nd + CW'(del_c);
                    if (r_ph == PH_TAIL) begin
                        if (e_st >= r_s) begin
                            r_ins <= j_idx;
                        end else begin
                            r_ph <= del_c ? PH_MID : PH_KEEP;
                        end
                    end else if (r_ph == PH_MID && !del_c) begin
                        r_ph <= PH_KEEP;
                    end
                end
            end
            L_W_WR: begin
                if (take_new) begin
                    r_newdone <= 1'b1;
                end else begin
                    r_k <= r_k + CW'(1);
                end
                if (live) begin
                    if (r_skip) begin
                        r_skip <= 1'b0;
                    end else begin
                        r_w <= r_w + CW'(1);
                    end
                end
            end
            default: ;
        endcase
    end

    assign o_st  = r_st;
    assign o_cnt = r_w;

endmodule

// ===== hw/rtl/temporal_fastest_path_onepass_top.sv =====
// ---------------------------------------------------------------------------
// temporal_fastest_path_onepass_top
// An edge searches the tail list and, when that search finds a pair, adds a
// pair to the head list; when the tail is the source, a pair is first added
// to the source list. Reads, refused edges and clears skip the list steps.
// One request at a time, taken again in the cycle the result strobe shows.
// The receiver cannot stall. After reset a clearing pass over all vertices runs.
// ---------------------------------------------------------------------------
module temporal_fastest_path_onepass_top #(
    parameter int VERTICES   = tfp_pkg::VERTICES_DEF,
    parameter int LIST_DEPTH = tfp_pkg::LIST_DEPTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [1:0]              i_command,
    input  logic [tfp_pkg::VPW-1:0] i_from_vertex,
    input  logic [tfp_pkg::VPW-1:0] i_to_vertex,
    input  logic [tfp_pkg::TW-1:0]  i_edge_start,
    input  logic [tfp_pkg::TW-1:0]  i_edge_duration,
    input  logic [tfp_pkg::VPW-1:0] i_query_vertex,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [1:0]              i_cfg_index,
    input  logic [tfp_pkg::TW-1:0]  i_cfg_data,
    output logic                    o_valid,
    output logic [tfp_pkg::VPW-1:0] o_result_vertex,
    output logic [tfp_pkg::TW-1:0]  o_best_duration,
    output logic                    o_reachable,
    output logic [tfp_pkg::VPW-1:0] o_predecessor,
    output logic                    o_improved,
    output logic                    o_window_closed,
    output logic                    o_list_overflow
);
    import tfp_pkg::*;

    localparam int VW = $clog2(VERTICES);
    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam int EW = 1 + TW + VPW + CW;

    function automatic logic inr(input logic [VPW-1:0] v);
        return 32'(v) < 32'(VERTICES);
    endfunction

    t_tstate        r_state, n_state;
    logic [VW-1:0]  r_ci;
    logic           r_clr_emit, r_closed, r_imp, r_ovf;
    logic [VPW-1:0] r_src, r_fv, r_tv, r_rv;
    logic [TW-1:0]  r_ws, r_we, r_es, r_arr;
    logic [EW-1:0]  r_ent;

    logic           vt_rd, vt_we;
    logic [VW-1:0]  vt_ra, vt_wa;
    logic [EW-1:0]  vt_q, vt_wd;

    t_lreq          l_req;
    t_lrsp          l_rsp;
    logic [VW-1:0]  l_vert;
    logic [TW-1:0]  l_s, l_a, l_st;
    logic [CW-1:0]  l_cnt_in, l_cnt;

    logic           acc, adm_c, cls_c, proc_c, upd_c, src_hit;
    logic [TW:0]    arr_c;
    logic [TW-1:0]  dur_c;
    t_cmd           cmd_c;

    logic           emit, em_reach;
    logic [TW-1:0]  em_time;
    logic [VPW-1:0] em_v, em_pred;
    logic           em_imp, em_cls, em_ovf;

    logic           r_o_valid, r_o_reach, r_o_imp, r_o_cls, r_o_ovf;
    logic [VPW-1:0] r_o_v, r_o_pred;
    logic [TW-1:0]  r_o_time;

    assign busy        = (r_state != T_IDLE);
    assign acc         = start && !busy;
    assign cmd_c       = t_cmd'(i_command);
    assign arr_c       = {1'b0, i_edge_start} + {1'b0, i_edge_duration};
    assign adm_c       = (i_edge_start >= r_ws) && (arr_c <= {1'b0, r_we});
    assign cls_c       = i_edge_start >= r_we;
    assign proc_c      = !r_closed && adm_c && inr(i_from_vertex) && inr(i_to_vertex);
    assign dur_c       = r_arr - l_st;
    assign upd_c       = dur_c < r_ent[CW+VPW +: TW];
    assign src_hit     = 32'(r_ci) == 32'(r_src);
    assign o_cfg_ready = 1'b1;

    tfp_vtab #(
        .DEPTH(VERTICES),
        .WIDTH(EW)
    ) u_vtab (
        .i_clk  (i_clk),
        .i_rd   (vt_rd),
        .i_raddr(vt_ra),
        .o_rdata(vt_q),
        .i_we   (vt_we),
        .i_waddr(vt_wa),
        .i_wdata(vt_wd)
    );

    tfp_list #(
        .VERTICES  (VERTICES),
        .LIST_DEPTH(LIST_DEPTH)
    ) u_list (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (l_req),
        .i_vert (l_vert),
        .i_s    (l_s),
        .i_a    (l_a),
        .i_cnt  (l_cnt_in),
        .o_rsp  (l_rsp),
        .o_st   (l_st),
        .o_cnt  (l_cnt)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            T_CLR: begin
                if (r_ci == VW'(VERTICES - 1)) begin
                    n_state = r_clr_emit ? T_ZERO : T_IDLE;
                end
            end
            T_IDLE: begin
                if (start) begin
                    case (cmd_c)
                        CMD_EDGE: begin
                            if (proc_c) begin
                                n_state = (i_from_vertex == r_src) ? T_SA_RD : T_F_RD;
                            end else begin
                                n_state = T_RV;
                            end
                        end
                        CMD_READ:  n_state = T_RV;
                        CMD_CLEAR: n_state = T_CLR;
                        default:   n_state = T_ZERO;
                    endcase
                end
            end
            T_ZERO:  n_state = T_IDLE;
            T_SA_RD: n_state = T_SA_GO;
            T_SA_GO: n_state = T_SA_WT;
            T_SA_WT: n_state = l_rsp.done ? T_F_RD : T_SA_WT;
            T_F_RD:  n_state = T_F_GO;
            T_F_GO:  n_state = T_F_WT;
            T_F_WT: begin
                if (l_rsp.done) begin
                    n_state = l_rsp.found ? T_T_RD : T_RV;
                end
            end
            T_T_RD:  n_state = T_T_GO;
            T_T_GO:  n_state = T_T_WT;
            T_T_WT:  n_state = l_rsp.done ? T_RV : T_T_WT;
            T_RV:    n_state = T_RV2;
            T_RV2:   n_state = T_IDLE;
            default: n_state = T_IDLE;
        endcase
    end

    always_comb begin
        vt_rd    = 1'b0;
        vt_ra    = VW'(r_fv);
        vt_we    = 1'b0;
        vt_wa    = VW'(r_fv);
        vt_wd    = {r_ent[EW-1:CW], l_cnt};
        l_req    = '0;
        l_vert   = VW'(r_fv);
        l_s      = r_es;
        l_a      = r_es;
        l_cnt_in = vt_q[CW-1:0];
        emit     = 1'b0;
        em_v     = r_rv;
        em_reach = 1'b0;
        em_time  = TMAX;
        em_pred  = '0;
        em_imp   = r_imp;
        em_cls   = r_closed;
        em_ovf   = r_ovf;
        case (r_state)
            T_CLR: begin
                vt_we = 1'b1;
                vt_wa = r_ci;
                vt_wd = src_hit ? {1'b1, TW'(0), r_src, CW'(0)}
                                : {1'b0, TMAX, VPW'(0), CW'(0)};
            end
            T_ZERO: begin
                emit    = 1'b1;
                em_v    = '0;
                em_time = '0;
                em_imp  = 1'b0;
                em_cls  = 1'b0;
                em_ovf  = 1'b0;
            end
            T_SA_RD, T_F_RD: vt_rd = 1'b1;
            T_SA_GO: begin
                l_req.go = 1'b1;
                l_req.op = LOP_ADD;
            end
            T_SA_WT: vt_we = l_rsp.done;
            T_F_GO: begin
                l_req.go = 1'b1;
                l_req.op = LOP_SEARCH;
            end
            T_T_RD: begin
                vt_rd = 1'b1;
                vt_ra = VW'(r_tv);
            end
            T_T_GO: begin
                l_req.go = 1'b1;
                l_req.op = LOP_ADD;
                l_vert   = VW'(r_tv);
                l_s      = l_st;
                l_a      = r_arr;
            end
            T_T_WT: begin
                vt_we = l_rsp.done;
                vt_wa = VW'(r_tv);
                vt_wd = upd_c ? {1'b1, dur_c, r_fv, l_cnt} : {r_ent[EW-1:CW], l_cnt};
            end
            T_RV: begin
                vt_rd = 1'b1;
                vt_ra = VW'(r_rv);
            end
            T_RV2: begin
                emit     = 1'b1;
                em_reach = inr(r_rv) && vt_q[EW-1];
                if (em_reach) begin
                    em_time = vt_q[CW+VPW +: TW];
                    em_pred = vt_q[CW +: VPW];
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= T_CLR;
            r_ci       <= '0;
            r_clr_emit <= 1'b0;
            r_closed   <= 1'b0;
            r_imp      <= 1'b0;
            r_ovf      <= 1'b0;
            r_src      <= '0;
            r_ws       <= '0;
            r_we       <= TMAX;
            r_o_valid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= emit;
            if (i_cfg_valid && o_cfg_ready) begin
                case (t_cfg'(i_cfg_index))
                    CFG_SOURCE: r_src <= i_cfg_data[VPW-1:0];
                    CFG_WSTART: r_ws  <= i_cfg_data;
                    CFG_WEND:   r_we  <= i_cfg_data;
                    default: ;
                endcase
            end
            case (r_state)
                T_CLR: begin
                    r_ci     <= r_ci + VW'(1);
                    r_closed <= 1'b0;
                end
                T_IDLE: begin
                    if (start) begin
                        r_imp <= 1'b0;
                        r_ovf <= 1'b0;
                        if (cmd_c == CMD_CLEAR) begin
                            r_ci       <= '0;
                            r_clr_emit <= 1'b1;
                        end
                        if (cmd_c == CMD_EDGE && !r_closed && !adm_c && cls_c) begin
                            r_closed <= 1'b1;
                        end
                    end
                end
                T_SA_WT: begin
                    if (l_rsp.done) begin
                        r_ovf <= r_ovf | l_rsp.ovf;
                    end
                end
                T_T_WT: begin
                    if (l_rsp.done) begin
                        r_ovf <= r_ovf | l_rsp.ovf;
                        r_imp <= upd_c;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_fv  <= i_from_vertex;
            r_tv  <= i_to_vertex;
            r_es  <= i_edge_start;
            r_arr <= arr_c[TW-1:0];
            r_rv  <= (cmd_c == CMD_READ) ? i_query_vertex : i_to_vertex;
        end
        if (r_state == T_SA_GO || r_state == T_T_GO) begin
            r_ent <= vt_q;
        end
        if (emit) begin
            r_o_v     <= em_v;
            r_o_time  <= em_time;
            r_o_reach <= em_reach;
            r_o_pred  <= em_pred;
            r_o_imp   <= em_imp;
            r_o_cls   <= em_cls;
            r_o_ovf   <= em_ovf;
        end
    end

    assign o_valid         = r_o_valid;
    assign o_result_vertex = r_o_v;
    assign o_best_duration = r_o_time;
    assign o_reachable     = r_o_reach;
    assign o_predecessor   = r_o_pred;
    assign o_improved      = r_o_imp;
    assign o_window_closed = r_o_cls;
    assign o_list_overflow = r_o_ovf;

endmodule

// ===== hw/rtl/tfp_checker.sv =====
// ---------------------------------------------------------------------------
// tfp_checker
// Port-level checks for the fastest temporal path engine.
// ---------------------------------------------------------------------------
module tfp_checker (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    start,
    input logic                    busy,
    input logic                    o_valid,
    input logic                    o_reachable,
    input logic                    o_improved,
    input logic [tfp_pkg::VPW-1:0] o_predecessor
);

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("request accepted without going busy");

    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result shown while busy");

    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("two results in a row");

    a_improved_reach: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_improved |-> o_reachable)
        else $error("improved vertex not reachable");

    a_unreach_pred: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_reachable |-> o_predecessor == '0)
        else $error("unreachable vertex carries a predecessor");

endmodule

bind temporal_fastest_path_onepass_top tfp_checker u_tfp_checker (.*);
